@@ rtl/earliest_departure_voq_scheduler_defines.svh @@
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef EARLIEST_DEPARTURE_VOQ_SCHEDULER_DEFINES_SVH
`define EARLIEST_DEPARTURE_VOQ_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define EDV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EDV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/edvs_pkg.sv @@
`default_nettype none

package edvs_pkg;

  localparam int GUARD_W     = 32;
  localparam int TIME_PORT_W = 48;
  localparam int IDX_W       = 5;
  localparam int CNT_W       = 6;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_GUARD    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAD = 1'd1;

  typedef enum logic [1:0] {
    CMD_SCHEDULE    = 2'd0,
    CMD_WRITE_FLAGS = 2'd1,
    CMD_WRITE_CHAN  = 2'd2,
    CMD_WRITE_RTT   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_DRAIN = 2'd2,
    ST_DONE  = 2'd3
  } state_t;

  typedef struct packed {
    cmd_t                   cmd;
    logic [IDX_W-1:0]       entry_index;
    logic [TIME_PORT_W-1:0] write_time;
    logic                   write_schedulable;
    logic                   write_nonempty;
    logic                   write_head_is_grant;
    logic [TIME_PORT_W-1:0] tx_free_time;
    logic [TIME_PORT_W-1:0] rx_free_time;
  } in_item_t;

  typedef struct packed {
    logic                   found;
    logic [IDX_W-1:0]       chosen_queue;
    logic [TIME_PORT_W-1:0] departure_time;
    logic [CNT_W-1:0]       cleared_count;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/earliest_departure_voq_scheduler.sv @@
// schedule transaction: ST_SCAN visits one queue per cycle, every queue once, issuing each
// schedulable non-empty one into a four-stage departure time unit, then ST_DRAIN drains it
// write transaction: applied on acceptance; each kind then loads its result in ST_DONE
// one transaction at a time: the next is accepted only in ST_IDLE, once ST_DONE is left,
// and out_stall can hold the result off in ST_DONE
// reset (synchronous, rst_n low): flags, valid bits, start index, guard and overhead cleared
`default_nettype none

module earliest_departure_voq_scheduler #(
  parameter int NUM_ONUS   = 16,
  parameter int TIME_WIDTH = 48
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  edvs_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output edvs_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [edvs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [edvs_pkg::GUARD_W-1:0]         cfg_wdata
);

  localparam int NQ   = 2 * NUM_ONUS;
  localparam int QW   = $clog2(NQ);
  localparam int OW   = (NUM_ONUS > 1) ? $clog2(NUM_ONUS) : 1;
  localparam int CW   = $clog2(NQ + 1);
  localparam int TW   = TIME_WIDTH;
  localparam int AW   = ((TW > edvs_pkg::GUARD_W) ? TW : edvs_pkg::GUARD_W) + 1;
  localparam int GW   = edvs_pkg::GUARD_W;
  localparam int IDXW = edvs_pkg::IDX_W;
  localparam int CNTW = edvs_pkg::CNT_W;
  localparam int OTW  = edvs_pkg::TIME_PORT_W;

  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [GW-1:0] b);
    logic [AW-1:0] s;
    s = AW'(a) + AW'(b);
    return (s[AW-1:TW] != '0) ? '1 : s[TW-1:0];
  endfunction

  edvs_pkg::state_t state_r, state_nxt;

  logic [GW-1:0]       guard_r, overhead_r;
  logic [NQ-1:0]       sched_r, nonempty_r, grant_r, chan_vld_r;
  logic [NUM_ONUS-1:0] rtt_vld_r;
  logic [TW-1:0]       chan_mem [NQ];
  logic [TW-1:0]       rtt_mem [NUM_ONUS];

  logic [QW-1:0] start_r, idx_r, cnt_r, winner_r;
  logic          is_sched_r;
  logic [TW-1:0] txg_r, rxg_r, best_r;
  logic          found_r;
  logic [CW-1:0] cleared_r;

  logic          p1_vld_r, p2_vld_r, p3_vld_r, p4_vld_r;
  logic          p1_gr_r, p2_gr_r, p3_gr_r;
  logic [QW-1:0] p1_q_r, p2_q_r, p3_q_r, p4_q_r;
  logic [TW-1:0] chan_rd_r, rtt_rd_r;
  logic          chan_rd_vld_r, rtt_rd_vld_r;
  logic [TW-1:0] cterm_r, sub_r, m1_r, rterm_r, t_r;

  logic                out_valid_r;
  edvs_pkg::out_item_t out_data_r, result;

  logic          accept, scan_en, issue, clear_q, pipe_busy, out_load, scan_last;
  logic          cur_sch, cur_ne, cur_gr;
  logic [QW-1:0] chan_full, chan_addr, idx_inc, winner_inc;
  logic [OW-1:0] cur_chan, wr_o;
  logic [QW-1:0] wr_q;
  logic          wr_q_ok, wr_o_ok;
  logic [TW-1:0] wtime, chan_val, rtt_val;

  // handshake and scan decode
  assign accept    = in_valid && !in_stall;
  assign scan_en   = (state_r == edvs_pkg::ST_SCAN);
  assign scan_last = (cnt_r == QW'(NQ - 1));
  assign cur_sch   = sched_r[idx_r];
  assign cur_ne    = nonempty_r[idx_r];
  assign cur_gr    = grant_r[idx_r];
  assign issue     = scan_en && cur_sch && cur_ne;
  assign clear_q   = scan_en && cur_sch && !cur_ne;
  assign pipe_busy = p1_vld_r || p2_vld_r || p3_vld_r || p4_vld_r;
  assign out_load  = (state_r == edvs_pkg::ST_DONE) && (!out_valid_r || !out_stall);

  // grant frames use the channel of queue index minus NUM_ONUS, wrapping below it
  assign chan_full  = (idx_r >= QW'(NUM_ONUS)) ? idx_r - QW'(NUM_ONUS) : idx_r;
  assign cur_chan   = OW'(chan_full);
  assign chan_addr  = cur_gr ? QW'(cur_chan) : idx_r;
  assign idx_inc    = (idx_r == QW'(NQ - 1)) ? '0 : idx_r + 1'b1;
  assign winner_inc = (winner_r == QW'(NQ - 1)) ? '0 : winner_r + 1'b1;

  assign wr_q    = QW'(in_data.entry_index);
  assign wr_o    = OW'(in_data.entry_index);
  assign wr_q_ok = int'(in_data.entry_index) < NQ;
  assign wr_o_ok = int'(in_data.entry_index) < NUM_ONUS;
  assign wtime   = TW'(in_data.write_time);

  assign chan_val = chan_rd_vld_r ? chan_rd_r : '0;
  assign rtt_val  = rtt_rd_vld_r ? rtt_rd_r : '0;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      edvs_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_data.cmd == edvs_pkg::CMD_SCHEDULE) ? edvs_pkg::ST_SCAN
                                                               : edvs_pkg::ST_DONE;
        end
      end
      edvs_pkg::ST_SCAN: begin
        if (scan_last) state_nxt = edvs_pkg::ST_DRAIN;
      end
      edvs_pkg::ST_DRAIN: begin
        if (!pipe_busy) state_nxt = edvs_pkg::ST_DONE;
      end
      edvs_pkg::ST_DONE: begin
        if (out_load) state_nxt = edvs_pkg::ST_IDLE;
      end
      default: state_nxt = edvs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != edvs_pkg::ST_IDLE);
    out_valid = out_valid_r;
    out_data  = out_data_r;
  end

  // write transactions return an all-zero result
  always_comb begin
    result = '0;
    if (is_sched_r) begin
      result.found          = found_r;
      result.chosen_queue   = IDXW'(winner_r);
      result.departure_time = found_r ? OTW'(best_r) : '1;
      result.cleared_count  = CNTW'(cleared_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= edvs_pkg::ST_IDLE;
      guard_r     <= '0;
      overhead_r  <= '0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
      p1_vld_r    <= 1'b0;
      p2_vld_r    <= 1'b0;
      p3_vld_r    <= 1'b0;
      p4_vld_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      p1_vld_r <= issue;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
      p4_vld_r <= p3_vld_r;
      if (cfg_we) begin
        unique case (cfg_index)
          edvs_pkg::CFG_GUARD:    guard_r    <= cfg_wdata;
          edvs_pkg::CFG_OVERHEAD: overhead_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == edvs_pkg::ST_DRAIN && !pipe_busy) begin
        start_r <= found_r ? winner_inc : '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // queue flags and store valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sched_r    <= '0;
      nonempty_r <= '0;
      grant_r    <= '0;
      chan_vld_r <= '0;
      rtt_vld_r  <= '0;
    end else begin
      if (accept && in_data.cmd == edvs_pkg::CMD_WRITE_FLAGS && wr_q_ok) begin
        sched_r[wr_q]    <= in_data.write_schedulable;
        nonempty_r[wr_q] <= in_data.write_nonempty;
        grant_r[wr_q]    <= in_data.write_head_is_grant;
      end
      if (accept && in_data.cmd == edvs_pkg::CMD_WRITE_CHAN && wr_q_ok) begin
        chan_vld_r[wr_q] <= 1'b1;
      end
      if (accept && in_data.cmd == edvs_pkg::CMD_WRITE_RTT && wr_o_ok) begin
        rtt_vld_r[wr_o] <= 1'b1;
      end
      if (clear_q) begin
        sched_r[idx_r] <= 1'b0;
      end
    end
  end

  // time stores, registered read; unwritten entries read as zero via the valid bits
  always_ff @(posedge clk) begin
    if (accept && in_data.cmd == edvs_pkg::CMD_WRITE_CHAN && wr_q_ok) begin
      chan_mem[wr_q] <= wtime;
    end
    if (accept && in_data.cmd == edvs_pkg::CMD_WRITE_RTT && wr_o_ok) begin
      rtt_mem[wr_o] <= wtime;
    end
    chan_rd_r     <= chan_mem[chan_addr];
    rtt_rd_r      <= rtt_mem[cur_chan];
    chan_rd_vld_r <= chan_vld_r[chan_addr];
    rtt_rd_vld_r  <= rtt_vld_r[cur_chan];
  end

  // departure time unit, shared by every queue of the scan
  always_ff @(posedge clk) begin
    p1_gr_r <= cur_gr;
    p1_q_r  <= idx_r;
    p2_gr_r <= p1_gr_r;
    p2_q_r  <= p1_q_r;
    cterm_r <= sat_add(chan_val, guard_r);
    sub_r   <= sat_add(rtt_val, overhead_r);
    p3_gr_r <= p2_gr_r;
    p3_q_r  <= p2_q_r;
    m1_r    <= (cterm_r > txg_r) ? cterm_r : txg_r;
    // receiver term clamps at zero
    rterm_r <= (rxg_r > sub_r) ? rxg_r - sub_r : '0;
    p4_q_r  <= p3_q_r;
    t_r     <= (p3_gr_r && rterm_r > m1_r) ? rterm_r : m1_r;
  end

  // scan sequencer and running minimum
  always_ff @(posedge clk) begin
    if (accept) begin
      is_sched_r <= (in_data.cmd == edvs_pkg::CMD_SCHEDULE);
      txg_r      <= sat_add(TW'(in_data.tx_free_time), guard_r);
      rxg_r      <= sat_add(TW'(in_data.rx_free_time), guard_r);
      idx_r      <= start_r;
      cnt_r      <= '0;
      found_r    <= 1'b0;
      best_r     <= '1;
      winner_r   <= '0;
      cleared_r  <= '0;
    end else begin
      if (scan_en) begin
        idx_r <= idx_inc;
        cnt_r <= cnt_r + 1'b1;
      end
      if (clear_q) begin
        cleared_r <= cleared_r + 1'b1;
      end
      // strict compare keeps the first queue met on a tie
      if (p4_vld_r && (!found_r || t_r < best_r)) begin
        found_r  <= 1'b1;
        best_r   <= t_r;
        winner_r <= p4_q_r;
      end
    end
    if (out_load) begin
      out_data_r <= result;
    end
  end

`include "earliest_departure_voq_scheduler_defines.svh"

  `EDV_ASSERT_NOW(a_update_while_scanning, p4_vld_r,
    state_r == edvs_pkg::ST_SCAN || state_r == edvs_pkg::ST_DRAIN,
    "minimum updated outside a scan")
  `EDV_ASSERT_NEXT(a_scan_length, scan_en && scan_last, state_r == edvs_pkg::ST_DRAIN,
    "scan did not end after every queue")
  `EDV_ASSERT_NOW(a_idle_pipe_on_accept, accept, !pipe_busy,
    "transaction accepted with the departure unit busy")
  `EDV_ASSERT_NOW(a_winner_eligible, state_r == edvs_pkg::ST_DONE && is_sched_r && found_r,
    sched_r[winner_r] && nonempty_r[winner_r], "winner is not a schedulable non-empty queue")
  `EDV_ASSERT_NOW(a_cleared_bound, state_r == edvs_pkg::ST_DONE, int'(cleared_r) <= NQ,
    "cleared count exceeds queue count")

endmodule

`default_nettype wire
